[hdl/bmpu_pkg.sv]
package bmpu_pkg;

  // Fixed geometry of the paged memory
  localparam int unsigned PageSize     = 16384;
  localparam int unsigned RamBanks     = 8;
  localparam int unsigned OffsetWidth  = $clog2(PageSize);
  localparam int unsigned BankWidth    = $clog2(RamBanks);
  localparam int unsigned PhysWidth    = OffsetWidth + BankWidth;
  localparam int unsigned AddrWidth    = 16;
  localparam int unsigned DataWidth    = 8;

  // Port decode masks and matches
  localparam logic [AddrWidth-1:0] PrimaryMask    = 16'hc002;
  localparam logic [AddrWidth-1:0] PrimaryMatch   = 16'h4000;
  localparam logic [AddrWidth-1:0] SecondaryMask  = 16'hf002;
  localparam logic [AddrWidth-1:0] SecondaryMatch = 16'h1000;

  // Fixed banks of the middle slots and the two screen banks
  localparam logic [BankWidth-1:0] Slot1Bank     = 3'd5;
  localparam logic [BankWidth-1:0] Slot2Bank     = 3'd2;
  localparam logic [BankWidth-1:0] NormalScreen  = 3'd5;
  localparam logic [BankWidth-1:0] ShadowScreen  = 3'd7;

  // Slot numbers
  localparam logic [1:0] SlotRom  = 2'd0;
  localparam logic [1:0] SlotLow  = 2'd1;
  localparam logic [1:0] SlotTop  = 2'd3;

  typedef enum logic [1:0] {
    KIND_MEM_RD = 2'd0,
    KIND_MEM_WR = 2'd1,
    KIND_IO_WR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TARGET_NONE = 2'd0,
    TARGET_ROM  = 2'd1,
    TARGET_RAM  = 2'd2,
    TARGET_RSVD = 2'd3
  } target_e;

  typedef struct packed {
    kind_e                kind;
    logic [AddrWidth-1:0] addr;
    logic [DataWidth-1:0] data;
  } req_t;

  typedef struct packed {
    logic [BankWidth-1:0] top_bank;
    logic                 rom_lo;
    logic                 rom_hi;
    logic                 shadow;
    logic                 locked;
  } state_t;

  typedef struct packed {
    target_e              target;
    logic [PhysWidth-1:0] phys;
    logic                 we;
    logic [DataWidth-1:0] wdata;
    logic                 cont;
    logic [BankWidth-1:0] disp;
    logic [1:0]           rom;
  } res_t;

endpackage

[hdl/banked_memory_paging_unit.sv]
// Bank-switching memory mapper for a 128 KiB paged machine.
// Requests enter on the s_axis channel: tuser carries the access kind
// (memory read, memory write, I/O write), tdata the address and the byte.
// Each request yields exactly one result on the m_axis channel: tuser carries
// the target (none, ROM, RAM), tdata the physical address, write strobe and
// byte, contention flag, display bank and selected ROM.
// The cfg channel writes the one-bit paging-present register; it is always
// ready and is meant to be written while no request is in flight.
// The accepting edge loads the input register; the mapped result moves into the
// result register at an edge where that register is free or being read. One
// request per cycle is sustained while the receiver keeps taking results; the
// paging state updates as a request moves into the result register, so the
// next request sees it without a bubble.
// When the receiver stalls, the result holds, the input register fills, and
// s_axis_tready drops only once both stages are occupied.
// Reset clears both stages and the paging state (ROM 0, top bank 0, display
// bank 5, unlocked) and sets paging-present.
module banked_memory_paging_unit
  import bmpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // address [15:0], data [23:16]
  input  logic [1:0]  s_axis_tuser,  // kind [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // physical_address [16:0], write_enable [17],
                                     // write_data [25:18], contended [26],
                                     // display_bank [29:27], rom_select [31:30]
  output logic [1:0]  m_axis_tuser,  // target [1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic   in_valid_q;
  req_t   req_q;
  logic   out_valid_q;
  res_t   res_q;
  res_t   res_d;
  state_t state;
  state_t state_d;
  logic   present;
  logic   out_free;
  logic   advance;
  logic   in_accept;

  // Pipeline handshake.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.kind <= kind_e'(s_axis_tuser);
      req_q.addr <= s_axis_tdata[AddrWidth-1:0];
      req_q.data <= s_axis_tdata[AddrWidth +: DataWidth];
    end
  end

  // Mapping logic and paging state.
  bmpu_map u_map (
    .req_i     (req_q),
    .state_i   (state),
    .present_i (present),
    .res_o     (res_d),
    .state_o   (state_d)
  );

  bmpu_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (advance),
    .state_d_i  (state_d),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .state_o    (state),
    .present_o  (present)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.target;
  assign m_axis_tdata  = {res_q.rom, res_q.disp, res_q.cont, res_q.wdata, res_q.we,
                          res_q.phys};

  // A RAM write strobe only goes with a RAM target.
  a_we_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.we) |-> (res_q.target == TARGET_RAM))
    else $error("write strobe without RAM target");

  // No target means no physical address and no write data.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.target == TARGET_NONE) |-> (res_q.phys == '0 && res_q.wdata == '0))
    else $error("unmapped result carries an address or data");

  // Display bank is always one of the two screen banks.
  a_disp_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.disp == NormalScreen || res_q.disp == ShadowScreen))
    else $error("display bank out of range");

endmodule

[hdl/bmpu_map.sv]
module bmpu_map
  import bmpu_pkg::*;
(
  input  req_t   req_i,
  input  state_t state_i,
  input  logic   present_i,
  output res_t   res_o,
  output state_t state_o
);

  logic [1:0]             slot;
  logic [OffsetWidth-1:0] offset;
  logic                   slot_cont;
  logic [BankWidth-1:0]   bank;
  logic                   primary_hit;
  logic                   secondary_hit;

  assign slot   = req_i.addr[AddrWidth-1 -: 2];
  assign offset = req_i.addr[OffsetWidth-1:0];

  // Contention uses the top bank held before this request.
  assign slot_cont = (slot == SlotLow) || ((slot == SlotTop) && state_i.top_bank[2]);

  // Bank behind each RAM slot.
  always_comb begin
    unique case (slot)
      SlotLow: bank = Slot1Bank;
      SlotTop: bank = state_i.top_bank;
      default: bank = Slot2Bank;
    endcase
  end

  assign primary_hit   = ((req_i.addr & PrimaryMask) == PrimaryMatch) && !state_i.locked;
  assign secondary_hit = ((req_i.addr & SecondaryMask) == SecondaryMatch) && !state_i.locked;

  // Next paging state: only I/O writes to an unlocked port change it.
  always_comb begin
    state_o = state_i;
    if (req_i.kind == KIND_IO_WR) begin
      if (primary_hit) begin
        state_o.locked   = state_i.locked | req_i.data[5];
        state_o.rom_lo   = req_i.data[4];
        state_o.shadow   = req_i.data[3];
        state_o.top_bank = req_i.data[BankWidth-1:0];
      end
      if (secondary_hit && !req_i.data[0]) begin
        state_o.rom_hi = req_i.data[2];
      end
    end
  end

  // Address translation and write strobe.
  always_comb begin
    res_o.target = TARGET_NONE;
    res_o.phys   = '0;
    res_o.we     = 1'b0;
    res_o.wdata  = '0;
    res_o.cont   = 1'b0;
    unique case (req_i.kind)
      KIND_MEM_RD, KIND_MEM_WR: begin
        res_o.cont = slot_cont;
        if (slot == SlotRom) begin
          if (req_i.kind == KIND_MEM_RD) begin
            res_o.target = TARGET_ROM;
            res_o.phys   = {1'b0, state_i.rom_hi, state_i.rom_lo, offset};
          end
        end else begin
          res_o.target = TARGET_RAM;
          res_o.phys   = {bank, offset};
          if (req_i.kind == KIND_MEM_WR) begin
            res_o.we    = 1'b1;
            res_o.wdata = req_i.data;
          end
        end
      end
      KIND_IO_WR: begin
        res_o.cont = present_i && slot_cont;
      end
      KIND_NONE: begin
        res_o.cont = 1'b0;
      end
      default: begin
        res_o.cont = 1'b0;
      end
    endcase
    // Status fields reflect the state after this request.
    res_o.disp = state_o.shadow ? ShadowScreen : NormalScreen;
    res_o.rom  = {state_o.rom_hi, state_o.rom_lo};
  end

endmodule

[hdl/bmpu_regs.sv]
module bmpu_regs
  import bmpu_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   upd_i,
  input  state_t state_d_i,
  input  logic   cfg_we_i,
  input  logic   cfg_data_i,
  output state_t state_o,
  output logic   present_o
);

  state_t state_q;
  logic   present_q;

  // Paging state advances once per request that leaves the mapping stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (upd_i) begin
      state_q <= state_d_i;
    end
  end

  // Configuration register, reset to paging hardware present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b1;
    end else if (cfg_we_i) begin
      present_q <= cfg_data_i;
    end
  end

  assign state_o   = state_q;
  assign present_o = present_q;

  // Once locked, the paging state is frozen until reset.
  a_lock_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.locked |=> $stable(state_q))
    else $error("paging state changed while locked");

endmodule

[dv/banked_memory_paging_unit_tb.sv]
`timescale 1ns / 100ps

module banked_memory_paging_unit_tb
  import bmpu_pkg::*;
();

  // Clock, reset and block inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;  // address [15:0], data [23:16]
  logic [1:0]  s_axis_tuser  = '0;  // kind [1:0]
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_data_i    = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;  // physical_address [16:0], write_enable [17],
                              // write_data [25:18], contended [26],
                              // display_bank [29:27], rom_select [31:30]
  logic [1:0]  m_axis_tuser;  // target [1:0]
  logic        cfg_ready_o;

  // Mirror of the paging state and the paging-present register
  state_t paging_state    = '0;
  logic   paging_present  = 1'b1;
  res_t   pending_maps[$];
  int     mismatch_count  = 0;
  bit     tx_idle_en      = 1'b0;
  bit     rx_idle_en      = 1'b0;
  int     rx_stall_left   = 0;

  banked_memory_paging_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Maps one access and applies its paging side effects to the mirrored state.
  function automatic res_t map_access(kind_e kind, logic [15:0] addr, logic [7:0] data);
    res_t       r;
    logic [1:0] slot;
    logic [13:0] offset;
    logic [2:0] bank;
    logic       hot_slot;
    r        = '0;
    slot     = addr[15:14];
    offset   = addr[13:0];
    // Contention uses the top bank as it was before this access.
    hot_slot = (slot == SlotLow) || (slot == SlotTop && paging_state.top_bank[2]);
    case (kind)
      KIND_MEM_RD, KIND_MEM_WR: begin
        r.cont = hot_slot;
        if (slot == SlotRom) begin
          // Writes into ROM space are dropped.
          if (kind == KIND_MEM_RD) begin
            r.target = TARGET_ROM;
            r.phys   = {1'b0, paging_state.rom_hi, paging_state.rom_lo, offset};
          end
        end else begin
          if (slot == SlotLow) begin
            bank = Slot1Bank;
          end else if (slot == SlotTop) begin
            bank = paging_state.top_bank;
          end else begin
            bank = Slot2Bank;
          end
          r.target = TARGET_RAM;
          r.phys   = {bank, offset};
          if (kind == KIND_MEM_WR) begin
            r.we    = 1'b1;
            r.wdata = data;
          end
        end
      end
      KIND_IO_WR: begin
        r.cont = paging_present && hot_slot;
        if ((addr & PrimaryMask) == PrimaryMatch && !paging_state.locked) begin
          if (data[5]) begin
            paging_state.locked = 1'b1;
          end
          paging_state.rom_lo   = data[4];
          paging_state.top_bank = data[2:0];
          paging_state.shadow   = data[3];
        end
        if ((addr & SecondaryMask) == SecondaryMatch && !paging_state.locked) begin
          // Special mode requests leave the ROM high bit alone.
          if (!data[0]) begin
            paging_state.rom_hi = data[2];
          end
        end
      end
      default: begin
      end
    endcase
    r.disp = paging_state.shadow ? ShadowScreen : NormalScreen;
    r.rom  = {paging_state.rom_hi, paging_state.rom_lo};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Sends one request, with an optional random gap ahead of it.
  task automatic send_access(kind_e kind, logic [15:0] addr, logic [7:0] data);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= kind;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_maps.push_back(map_access(kind, addr, data));
  endtask

  // Stops sending and waits until every result has come back.
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_paging_present(logic value);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    paging_present = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Picks a random access; most I/O writes aim at one of the paging ports.
  task automatic pick_access(bit allow_lock, output kind_e kind, output logic [15:0] addr,
                             output logic [7:0] data);
    int roll;
    roll = $urandom_range(0, 99);
    addr = 16'($urandom_range(0, 65535));
    data = 8'($urandom_range(0, 255));
    if (roll < 30) begin
      kind = KIND_MEM_RD;
    end else if (roll < 50) begin
      kind = KIND_MEM_WR;
    end else if (roll < 93) begin
      kind = KIND_IO_WR;
    end else begin
      kind = KIND_NONE;
    end
    if (kind == KIND_IO_WR) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        addr = (addr & ~PrimaryMask) | PrimaryMatch;
      end else if (roll < 7) begin
        addr = (addr & ~SecondaryMask) | SecondaryMatch;
      end
      // Keep the lock clear unless this stretch may set it.
      if (!allow_lock) begin
        data[5] = 1'b0;
      end
    end else if ($urandom_range(0, 9) == 0) begin
      // Slot boundaries.
      addr[13:0] = $urandom_range(0, 1) ? 14'h3fff : 14'h0000;
    end
  endtask

  task automatic test_slot_mapping;
    send_access(KIND_MEM_RD, 16'h0000, 8'h00);
    send_access(KIND_MEM_RD, 16'h3fff, 8'hff);
    send_access(KIND_MEM_WR, 16'h0000, 8'hff);
    send_access(KIND_MEM_RD, 16'h4000, 8'h00);
    send_access(KIND_MEM_WR, 16'h7fff, 8'ha5);
    send_access(KIND_MEM_RD, 16'h8000, 8'h00);
    send_access(KIND_MEM_WR, 16'hbfff, 8'h5a);
    send_access(KIND_MEM_RD, 16'hc000, 8'h00);
    send_access(KIND_NONE,   16'hffff, 8'hff);
    drain();
  endtask

  task automatic test_paging_ports;
    send_access(KIND_IO_WR,  16'h7ffd, 8'h17);
    send_access(KIND_MEM_RD, 16'hffff, 8'h00);
    send_access(KIND_IO_WR,  16'h1ffd, 8'h04);
    send_access(KIND_MEM_RD, 16'h1234, 8'h00);
    // Special mode request on the secondary port changes nothing.
    send_access(KIND_IO_WR,  16'h1ffd, 8'h05);
    send_access(KIND_IO_WR,  16'h1ffd, 8'h00);
    send_access(KIND_IO_WR,  16'h7ffd, 8'h08);
    send_access(KIND_IO_WR,  16'hffff, 8'hff);
    send_access(KIND_MEM_RD, 16'hc000, 8'h00);
    send_access(KIND_IO_WR,  16'h7ffd, 8'h00);
    drain();
  endtask

  task automatic test_paging_present;
    write_paging_present(1'b0);
    send_access(KIND_IO_WR,  16'h4001, 8'h04);
    send_access(KIND_IO_WR,  16'hc0ff, 8'h00);
    send_access(KIND_MEM_RD, 16'hc000, 8'h00);
    write_paging_present(1'b1);
    send_access(KIND_IO_WR,  16'hc0ff, 8'h00);
    send_access(KIND_IO_WR,  16'h4002, 8'hff);
    send_access(KIND_IO_WR,  16'h8000, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic(int count, bit allow_lock);
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    repeat (count) begin
      pick_access(allow_lock, kind, addr, data);
      send_access(kind, addr, data);
    end
    drain();
  endtask

  // The lock holds until reset, so only lock-enabled random traffic follows this.
  task automatic test_paging_lock;
    send_access(KIND_IO_WR,  16'h7ffd, 8'h23);
    send_access(KIND_IO_WR,  16'h7ffd, 8'h07);
    send_access(KIND_IO_WR,  16'h1ffd, 8'h04);
    send_access(KIND_MEM_RD, 16'hc000, 8'h00);
    send_access(KIND_MEM_RD, 16'h0000, 8'h00);
    drain();
  endtask

  // Receiver stalls come in random bursts while enabled.
  always @(negedge clk_i) begin
    if (rx_idle_en && rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_stall_left <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Each result is checked against the oldest pending mapping.
  always @(posedge clk_i) begin : check_result
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        want = pending_maps.pop_front();
        if (2'(want.target) !== m_axis_tuser) begin
          report_mismatch("target", 32'(want.target), 32'(m_axis_tuser));
        end
        if (want.phys !== m_axis_tdata[16:0]) begin
          report_mismatch("physical_address", 32'(want.phys), 32'(m_axis_tdata[16:0]));
        end
        if (want.we !== m_axis_tdata[17]) begin
          report_mismatch("write_enable", 32'(want.we), 32'(m_axis_tdata[17]));
        end
        if (want.wdata !== m_axis_tdata[25:18]) begin
          report_mismatch("write_data", 32'(want.wdata), 32'(m_axis_tdata[25:18]));
        end
        if (want.cont !== m_axis_tdata[26]) begin
          report_mismatch("contended", 32'(want.cont), 32'(m_axis_tdata[26]));
        end
        if (want.disp !== m_axis_tdata[29:27]) begin
          report_mismatch("display_bank", 32'(want.disp), 32'(m_axis_tdata[29:27]));
        end
        if (want.rom !== m_axis_tdata[31:30]) begin
          report_mismatch("rom_select", 32'(want.rom), 32'(m_axis_tdata[31:30]));
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_slot_mapping();
    test_paging_ports();
    test_paging_present();
    test_random_traffic(600, 1'b0);
    write_paging_present(1'b0);
    test_random_traffic(500, 1'b0);
    write_paging_present(1'b1);
    // Final stretch runs at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(450, 1'b0);
    test_paging_lock();
    test_random_traffic(100, 1'b1);
    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
